// ===== rtl/core/bpr_sgd_pkg.sv =====
// Package for the BPR factor SGD core: sizes, codes, shared structs,
// saturation helper and the sigmoid table built at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package bpr_sgd_pkg;

   // Table sizes and number format
   localparam int NUM_USERS = 1024;
   localparam int NUM_ITEMS = 4096;
   localparam int FACTORS   = 16;
   localparam int FRAC_BITS = 16;

   localparam int USER_W  = 10;
   localparam int ITEM_W  = 12;
   localparam int K_W     = 4;
   localparam int CSR_W   = 16;
   localparam int UADDR_W = USER_W + K_W;
   localparam int IADDR_W = ITEM_W + K_W;

   localparam logic [63:0]        EXP_STEP_Q32 = 64'd4162825044;
   localparam logic signed [63:0] SAT_MAX      = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN      = -64'sd2147483648;
   // 1.0 in the stored format
   localparam logic signed [32:0] ONE_Q        = 33'sd1 <<< FRAC_BITS;

   typedef enum logic [2:0] {
      ACT_WR_USER = 3'd0,
      ACT_WR_ITEM = 3'd1,
      ACT_WR_BIAS = 3'd2,
      ACT_PREDICT = 3'd3,
      ACT_UPDATE  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CSR_LEARN_RATE = 2'd0,
      CSR_FACTOR_REG = 2'd1,
      CSR_BIAS_REG   = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      DST_BIAS_P = 3'd0,
      DST_BIAS_N = 3'd1,
      DST_USER   = 3'd2,
      DST_ITEM_P = 3'd3,
      DST_ITEM_N = 3'd4
   } dest_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIAS_P,
      ST_BIAS_N,
      ST_BIAS_X,
      ST_RD_P,
      ST_RD_N,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_SIG,
      ST_FB_P,
      ST_FB_N,
      ST_FU,
      ST_FP,
      ST_FN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // One step request into the update unit
   typedef struct packed {
      logic                valid;
      logic signed [31:0]  x;
      logic [15:0]         w;
      logic signed [32:0]  y;
      logic                neg;
      dest_type            dest;
      logic [IADDR_W-1:0]  addr;
   } upd_req_type;

   // Write-back from the update unit
   typedef struct packed {
      logic                valid;
      logic                sat;
      dest_type            dest;
      logic [IADDR_W-1:0]  addr;
      logic signed [31:0]  value;
   } upd_wr_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] value;
   } sat_type;

   typedef logic [255:0][16:0] sig_rom_type;

   // Clip to the signed 32-bit range
   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r.sat   = 1'b1;
         r.value = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r.sat   = 1'b1;
         r.value = 32'sh80000000;
      end else begin
         r.sat   = 1'b0;
         r.value = v[31:0];
      end
      return r;
   endfunction

   // Restoring long division, used only while building the table
   function automatic logic [16:0] div_q(input logic [48:0] num, input logic [32:0] den);
      logic [33:0] rem;
      logic [48:0] q;
      int          i;
      rem = '0;
      q   = '0;
      for (i = 48; i >= 0; i--) begin
         rem = {rem[32:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q[16:0];
   endfunction

   // Sigmoid at the midpoint of each 1/16 step over [-8, 8), Q0.16
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      logic [63:0] p;
      logic [32:0] den;
      logic [48:0] num;
      logic [16:0] val;
      int          n;
      int          i;
      rom = '0;
      p   = 64'h1_0000_0000;
      for (n = 1; n <= 255; n++) begin
         p = (p * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
         if (n % 2 == 1) begin
            i   = (255 - n) / 2;
            den = 33'h1_0000_0000 + p[32:0];
            num = {p[32:0], 16'h0000} + {16'h0000, den[32:1]};
            val = div_q(num, den);
            rom[i[7:0]]         = val;
            rom[8'(255 - i)]    = 17'd65536 - val;
         end
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

// ===== rtl/core/bpr_sgd_if.sv =====
// Handshake channels of the BPR factor SGD core: request and response.
// No dependencies.
`timescale 1ns / 1ps

interface bpr_sgd_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [9:0]         user_index;
   logic [11:0]        pos_item_index;
   logic [11:0]        neg_item_index;
   logic [3:0]         factor_index;
   logic signed [31:0] write_value;

   modport source (output valid, action, user_index, pos_item_index, neg_item_index,
                   factor_index, write_value, input ready);
   modport sink (input valid, action, user_index, pos_item_index, neg_item_index,
                 factor_index, write_value, output ready);
endinterface

interface bpr_sgd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] score;
   logic               saturated;

   modport source (output valid, score, saturated, input ready);
   modport sink (input valid, score, saturated, output ready);
endinterface

// ===== rtl/core/bpr_sgd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bpr_sgd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bpr_sgd_upd.sv =====
// Three-stage SGD update datapath: new = sat(x + rnd(lr*(g - rnd(w*x)))),
// g = +/-rnd(tau*y). Depends on bpr_sgd_pkg.
`timescale 1ns / 1ps

module bpr_sgd_upd import bpr_sgd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [16:0] tau,
   input  logic [15:0] step_rate,
   input  upd_req_type req,
   output upd_wr_type  wr,
   output logic        busy
);

   // stage 1: regularisation term and gradient term
   logic signed [48:0] wx_prod;
   logic signed [49:0] wx_rnd;
   logic signed [50:0] ty_prod;
   logic signed [51:0] ty_rnd;
   logic signed [35:0] g_pos;
   logic signed [36:0] g_in;
   logic signed [33:0] r_in;

   logic               v1_ff;
   logic signed [31:0] x1_ff;
   logic signed [33:0] r1_ff;
   logic signed [36:0] g1_ff;
   dest_type           dest1_ff;
   logic [IADDR_W-1:0] addr1_ff;

   // stage 2: step scaled by the learning rate
   logic signed [37:0] diff;
   logic signed [54:0] m_in;

   logic               v2_ff;
   logic signed [31:0] x2_ff;
   logic signed [54:0] m2_ff;
   dest_type           dest2_ff;
   logic [IADDR_W-1:0] addr2_ff;

   // stage 3: round, add, clip
   logic signed [55:0] m_rnd;
   logic signed [39:0] rm;
   logic signed [63:0] sum;
   sat_type            res;
   upd_wr_type         wr_ff;

   always_comb begin
      wx_prod = $signed({1'b0, req.w}) * req.x;
      wx_rnd  = {wx_prod[48], wx_prod} + 50'sd32768;
      r_in    = wx_rnd[49:16];
      ty_prod = $signed({1'b0, tau}) * req.y;
      ty_rnd  = {ty_prod[50], ty_prod} + 52'sd32768;
      g_pos   = ty_rnd[51:16];
      g_in    = req.neg ? -{g_pos[35], g_pos} : {g_pos[35], g_pos};
   end

   always_comb begin
      diff = {g1_ff[36], g1_ff} - {{4{r1_ff[33]}}, r1_ff};
      m_in = $signed({1'b0, step_rate}) * diff;
   end

   always_comb begin
      m_rnd = {m2_ff[54], m2_ff} + 56'sd32768;
      rm    = m_rnd[55:16];
      sum   = {{24{rm[39]}}, rm} + {{32{x2_ff[31]}}, x2_ff};
      res   = sat32(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         wr_ff.valid <= 1'b0;
      end else begin
         v1_ff       <= req.valid;
         v2_ff       <= v1_ff;
         wr_ff.valid <= v2_ff;
      end
      x1_ff    <= req.x;
      r1_ff    <= r_in;
      g1_ff    <= g_in;
      dest1_ff <= req.dest;
      addr1_ff <= req.addr;
      x2_ff    <= x1_ff;
      m2_ff    <= m_in;
      dest2_ff <= dest1_ff;
      addr2_ff <= addr1_ff;
      wr_ff.sat   <= res.sat;
      wr_ff.value <= res.value;
      wr_ff.dest  <= dest2_ff;
      wr_ff.addr  <= addr2_ff;
   end

   assign wr   = wr_ff;
   assign busy = v1_ff | v2_ff | wr_ff.valid;

endmodule

// ===== rtl/core/bpr_factor_sgd_update_core.sv =====
// Top level of the BPR matrix-factorisation SGD core: sequencer, tables,
// configuration registers. Depends on bpr_sgd_pkg, bpr_sgd_if, bpr_sgd_ram, bpr_sgd_upd.
`timescale 1ns / 1ps

// Item biases, user factor rows and item factor rows live in three RAMs with a
// registered read; every beat is handled by one sequencer that reads, computes
// and writes back one factor position at a time. After reset the bias RAM is
// swept to zero, during which no request beat is taken (configuration writes
// are taken throughout). A write action goes straight to the done state; predict
// reads the biases, then multiplies and accumulates each factor in turn; update
// adds the sigmoid, both bias steps, a write-back pass over the factors and a
// pipeline drain. The done state waits for a free result register, and idle
// follows before the next beat is taken; the item RAM's single read port is
// read twice per factor, for the positive and negative item. A finished result
// waits in an output register while the next request beat is taken. Factor
// entries must be written before predict or update reads them.
module bpr_factor_sgd_update_core import bpr_sgd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bpr_sgd_req_if.sink        req_ch,
   bpr_sgd_rsp_if.source      rsp_ch,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   state_type          state_ff, state_in;
   logic [ITEM_W-1:0]  clr_ff, clr_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic               pass2_ff, pass2_in;
   action_type         act_ff, act_in;
   logic [USER_W-1:0]  uidx_ff, uidx_in;
   logic [ITEM_W-1:0]  pidx_ff, pidx_in;
   logic [ITEM_W-1:0]  nidx_ff, nidx_in;
   logic signed [31:0] bp_ff, bp_in, bn_ff, bn_in;
   logic signed [31:0] u_ff, u_in, p_ff, p_in, n_ff, n_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [64:0] prod_ff, prod_in;
   logic signed [31:0] acc_ff, acc_in;
   logic               sat_ff, sat_in;
   logic [16:0]        tau_ff, tau_in;
   logic [CSR_W-1:0]   lr_ff, lr_in, fr_ff, fr_in, br_ff, br_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_score_ff, rsp_score_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic               req_fire;
   logic               rsp_free;
   logic               k_last;
   action_type         req_act;

   // RAM ports
   logic               bias_we;
   logic [ITEM_W-1:0]  bias_waddr, bias_raddr;
   logic [31:0]        bias_wdata, bias_rdata;
   logic               user_we;
   logic [UADDR_W-1:0] user_waddr, user_raddr;
   logic [31:0]        user_wdata, user_rdata;
   logic               item_we;
   logic [IADDR_W-1:0] item_waddr, item_raddr;
   logic [31:0]        item_wdata, item_rdata;

   upd_req_type        upd_req;
   upd_wr_type         upd_wr;
   logic               upd_busy;

   // datapath helpers
   sat_type            bias_diff;
   sat_type            acc_sum;
   logic signed [65:0] prod_rnd;
   logic signed [65:0] prod_sh;
   logic signed [32:0] neg_acc;
   logic signed [33:0] sig_arg;
   logic signed [33:0] sig_sh;
   logic [7:0]         sig_idx;

   assign req_act  = action_type'(req_ch.action);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign k_last   = (k_ff == K_W'(FACTORS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ITEM_W'(NUM_ITEMS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_act == ACT_PREDICT || req_act == ACT_UPDATE) state_in = ST_BIAS_P;
               else state_in = ST_DONE;
            end
         end
         ST_BIAS_P: state_in = ST_BIAS_N;
         ST_BIAS_N: state_in = ST_BIAS_X;
         ST_BIAS_X: state_in = ST_RD_P;
         ST_RD_P:   state_in = ST_RD_N;
         ST_RD_N:   state_in = ST_DIFF;
         ST_DIFF:   state_in = pass2_ff ? ST_FU : ST_MUL;
         ST_MUL:    state_in = ST_ACC;
         ST_ACC: begin
            if (!k_last) state_in = ST_RD_P;
            else if (act_ff == ACT_PREDICT) state_in = ST_DONE;
            else state_in = ST_SIG;
         end
         ST_SIG:    state_in = ST_FB_P;
         ST_FB_P:   state_in = ST_FB_N;
         ST_FB_N:   state_in = ST_RD_P;
         ST_FU:     state_in = ST_FP;
         ST_FP:     state_in = ST_FN;
         ST_FN:     state_in = k_last ? ST_DRAIN : ST_RD_P;
         ST_DRAIN: begin
            if (!upd_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs: RAM ports, update unit feed
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);

      bias_we    = 1'b0;
      bias_waddr = pidx_ff;
      bias_wdata = '0;
      bias_raddr = (state_ff == ST_BIAS_P) ? pidx_ff : nidx_ff;
      user_we    = 1'b0;
      user_waddr = {uidx_ff, k_ff};
      user_wdata = upd_wr.value;
      user_raddr = {uidx_ff, k_ff};
      item_we    = 1'b0;
      item_waddr = upd_wr.addr;
      item_wdata = upd_wr.value;
      item_raddr = (state_ff == ST_RD_P) ? {pidx_ff, k_ff} : {nidx_ff, k_ff};

      if (state_ff == ST_CLEAR) begin
         bias_we    = 1'b1;
         bias_waddr = clr_ff;
      end else if (req_fire) begin
         case (req_act)
            ACT_WR_USER: begin
               user_we    = 1'b1;
               user_waddr = {req_ch.user_index, req_ch.factor_index};
               user_wdata = req_ch.write_value;
            end
            ACT_WR_ITEM: begin
               item_we    = 1'b1;
               item_waddr = {req_ch.pos_item_index, req_ch.factor_index};
               item_wdata = req_ch.write_value;
            end
            ACT_WR_BIAS: begin
               bias_we    = 1'b1;
               bias_waddr = req_ch.pos_item_index;
               bias_wdata = req_ch.write_value;
            end
            default: ;
         endcase
      end else if (upd_wr.valid) begin
         case (upd_wr.dest)
            DST_BIAS_P, DST_BIAS_N: begin
               bias_we    = 1'b1;
               bias_waddr = upd_wr.addr[ITEM_W-1:0];
               bias_wdata = upd_wr.value;
            end
            DST_USER: begin
               user_we    = 1'b1;
               user_waddr = upd_wr.addr[UADDR_W-1:0];
            end
            DST_ITEM_P, DST_ITEM_N: begin
               item_we = 1'b1;
            end
            default: ;
         endcase
      end

      upd_req       = '0;
      upd_req.w     = fr_ff;
      upd_req.y     = ONE_Q;
      upd_req.dest  = DST_BIAS_P;
      case (state_ff)
         ST_FB_P: begin
            upd_req.valid = 1'b1;
            upd_req.x     = bp_ff;
            upd_req.w     = br_ff;
            upd_req.addr  = IADDR_W'(pidx_ff);
         end
         ST_FB_N: begin
            upd_req.valid = 1'b1;
            upd_req.x     = bn_ff;
            upd_req.w     = br_ff;
            upd_req.neg   = 1'b1;
            upd_req.dest  = DST_BIAS_N;
            upd_req.addr  = IADDR_W'(nidx_ff);
         end
         ST_FU: begin
            upd_req.valid = 1'b1;
            upd_req.x     = u_ff;
            upd_req.y     = d_ff;
            upd_req.dest  = DST_USER;
            upd_req.addr  = IADDR_W'({uidx_ff, k_ff});
         end
         ST_FP: begin
            upd_req.valid = 1'b1;
            upd_req.x     = p_ff;
            upd_req.y     = {u_ff[31], u_ff};
            upd_req.dest  = DST_ITEM_P;
            upd_req.addr  = {pidx_ff, k_ff};
         end
         ST_FN: begin
            upd_req.valid = 1'b1;
            upd_req.x     = n_ff;
            upd_req.y     = {u_ff[31], u_ff};
            upd_req.neg   = 1'b1;
            upd_req.dest  = DST_ITEM_N;
            upd_req.addr  = {nidx_ff, k_ff};
         end
         default: ;
      endcase
   end

   // arithmetic on the read-back values
   always_comb begin
      bias_diff = sat32(64'(bp_ff) - 64'($signed(bias_rdata)));
      prod_rnd  = {prod_ff[64], prod_ff} + (66'sd1 <<< (FRAC_BITS - 1));
      prod_sh   = prod_rnd >>> FRAC_BITS;
      acc_sum   = sat32(prod_sh[63:0] + 64'(acc_ff));
      neg_acc   = -{acc_ff[31], acc_ff};
      sig_arg   = {neg_acc[32], neg_acc} + (34'sd8 <<< FRAC_BITS);
      sig_sh    = sig_arg >>> (FRAC_BITS - 4);
      if (sig_arg[33]) sig_idx = 8'd0;
      else if (sig_sh > 34'sd255) sig_idx = 8'd255;
      else sig_idx = sig_sh[7:0];
   end

   // datapath and register next values
   always_comb begin
      clr_in   = clr_ff;
      k_in     = k_ff;
      pass2_in = pass2_ff;
      act_in   = act_ff;
      uidx_in  = uidx_ff;
      pidx_in  = pidx_ff;
      nidx_in  = nidx_ff;
      bp_in    = bp_ff;
      bn_in    = bn_ff;
      u_in     = u_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      tau_in   = tau_ff;

      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            if (req_fire) begin
               act_in   = req_act;
               uidx_in  = req_ch.user_index;
               pidx_in  = req_ch.pos_item_index;
               nidx_in  = req_ch.neg_item_index;
               k_in     = '0;
               pass2_in = 1'b0;
               acc_in   = '0;
               sat_in   = 1'b0;
            end
         end
         ST_BIAS_N: bp_in = bias_rdata;
         ST_BIAS_X: begin
            bn_in = bias_rdata;
            if (act_ff == ACT_PREDICT) begin
               acc_in = bp_ff;
            end else begin
               acc_in = bias_diff.value;
               sat_in = sat_ff | bias_diff.sat;
            end
         end
         ST_RD_N: begin
            u_in = user_rdata;
            p_in = item_rdata;
         end
         ST_DIFF: begin
            n_in = item_rdata;
            if (act_ff == ACT_PREDICT) d_in = {p_ff[31], p_ff};
            else d_in = {p_ff[31], p_ff} - {item_rdata[31], item_rdata};
         end
         ST_MUL: prod_in = u_ff * d_ff;
         ST_ACC: begin
            acc_in = acc_sum.value;
            sat_in = sat_ff | acc_sum.sat;
            k_in   = k_ff + 1'b1;
         end
         ST_SIG: tau_in = SIG_ROM[sig_idx];
         ST_FB_N: begin
            k_in     = '0;
            pass2_in = 1'b1;
         end
         ST_FN: k_in = k_ff + 1'b1;
         default: ;
      endcase

      // clipped write-backs count towards the flag
      if (upd_wr.valid && upd_wr.sat) sat_in = 1'b1;
   end

   // configuration registers and result register
   always_comb begin
      lr_in = lr_ff;
      fr_in = fr_ff;
      br_in = br_ff;
      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_LEARN_RATE: lr_in = csr_wdata;
            CSR_FACTOR_REG: fr_in = csr_wdata;
            CSR_BIAS_REG:   br_in = csr_wdata;
            default: ;
         endcase
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_score_in = rsp_score_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_score_in = acc_ff;
         rsp_sat_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         pass2_ff     <= 1'b0;
         act_ff       <= ACT_WR_USER;
         sat_ff       <= 1'b0;
         lr_ff        <= 16'd3277;
         fr_ff        <= 16'd655;
         br_ff        <= 16'd655;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         pass2_ff     <= pass2_in;
         act_ff       <= act_in;
         sat_ff       <= sat_in;
         lr_ff        <= lr_in;
         fr_ff        <= fr_in;
         br_ff        <= br_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      uidx_ff      <= uidx_in;
      pidx_ff      <= pidx_in;
      nidx_ff      <= nidx_in;
      bp_ff        <= bp_in;
      bn_ff        <= bn_in;
      u_ff         <= u_in;
      p_ff         <= p_in;
      n_ff         <= n_in;
      d_ff         <= d_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      tau_ff       <= tau_in;
      rsp_score_ff <= rsp_score_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.score     = rsp_score_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // tables
   bpr_sgd_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (bias_waddr),
      .wr_data (bias_wdata),
      .rd_addr (bias_raddr),
      .rd_data (bias_rdata)
   );

   bpr_sgd_ram #(.WIDTH(32), .DEPTH(NUM_USERS * FACTORS)) u_user_ram (
      .clock   (clock),
      .wr_en   (user_we),
      .wr_addr (user_waddr),
      .wr_data (user_wdata),
      .rd_addr (user_raddr),
      .rd_data (user_rdata)
   );

   bpr_sgd_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS * FACTORS)) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_waddr),
      .wr_data (item_wdata),
      .rd_addr (item_raddr),
      .rd_data (item_rdata)
   );

   // update datapath
   bpr_sgd_upd u_upd (
      .clock      (clock),
      .reset      (reset),
      .tau        (tau_ff),
      .step_rate  (lr_ff),
      .req        (upd_req),
      .wr         (upd_wr),
      .busy       (upd_busy)
   );

`ifndef SYNTHESIS
   a_idle_no_writeback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !upd_busy)
      else $error("update write-back still in flight while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");

   a_feed_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FU || state_ff == ST_FP || state_ff == ST_FN)
      |-> (pass2_ff && act_ff == ACT_UPDATE))
      else $error("factor write-back issued outside an update");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for bpr_factor_sgd_update_core: directed and random
// request beats, with a built-in predictor of scores, tables and flags.
// Depends on bpr_sgd_pkg, bpr_sgd_if and the RTL core.
`timescale 1ns / 1ps

module tb;
   import bpr_sgd_pkg::*;

   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam int         IDLE_LIMIT  = 30000;
   localparam int         DRAIN_WAIT  = 250;

   typedef struct {
      int signed score;
      bit        sat;
   } score_beat_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   bpr_sgd_req_if req_ch();
   bpr_sgd_rsp_if rsp_ch();

   bpr_factor_sgd_update_core i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor state
   int signed      bias_mem[NUM_ITEMS];
   int signed      user_mem[NUM_USERS*FACTORS];
   int signed      item_mem[NUM_ITEMS*FACTORS];
   logic [15:0]    user_wr_mask[NUM_USERS];
   logic [15:0]    item_wr_mask[NUM_ITEMS];
   int             user_pool[$];
   int             item_pool[$];
   longint         step_rate, factor_reg, bias_reg;
   logic [16:0]    sigmoid_lut[256];
   bit             clip_hit;
   score_beat_type expected_scores[$];
   int             errors = 0;
   bit             no_idle = 1'b0;
   bit             rsp_taken = 1'b0;
   int             rsp_stall = 0;
   int             idle_cycles = 0;

   function automatic void build_sigmoid();
      logic [63:0] p, den, val;
      int          i;
      p = 64'h1_0000_0000;
      for (int n = 1; n <= 255; n++) begin
         p = (p * 64'd4162825044 + 64'h8000_0000) >> 32;
         if (n % 2 == 1) begin
            i   = (255 - n) / 2;
            den = 64'h1_0000_0000 + p;
            val = ((p << 16) + den / 2) / den;
            sigmoid_lut[i]       = val[16:0];
            sigmoid_lut[255 - i] = 17'd65536 - val[16:0];
         end
      end
   endfunction

   function automatic longint rnd16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) begin
         clip_hit = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clip_hit = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic void mark_user(int u, int k);
      user_wr_mask[u][k] = 1'b1;
      if (user_wr_mask[u] == 16'hffff && !(u inside {user_pool}))
         user_pool.insert(user_pool.size(), u);
   endfunction

   function automatic void mark_item(int ip, int k);
      item_wr_mask[ip][k] = 1'b1;
      if (item_wr_mask[ip] == 16'hffff && !(ip inside {item_pool}))
         item_pool.insert(item_pool.size(), ip);
   endfunction

   // Expected score and flag of one beat, with table updates
   function automatic score_beat_type score_step(logic [2:0] act, int u, int ip, int jn,
                                                 int fi, int signed wv);
      score_beat_type r;
      longint x, bp, bn, tau, uk, pk, nk, tu, nu, np, nn, nbp, nbn, t, idx;
      x = 0;
      clip_hit = 1'b0;
      case (act)
         ACT_WR_USER: begin
            user_mem[u*FACTORS + fi] = wv;
            mark_user(u, fi);
         end
         ACT_WR_ITEM: begin
            item_mem[ip*FACTORS + fi] = wv;
            mark_item(ip, fi);
         end
         ACT_WR_BIAS: bias_mem[ip] = wv;
         ACT_PREDICT: begin
            x = bias_mem[ip];
            for (int k = 0; k < FACTORS; k++)
               x = clip32(x + rnd16(longint'(user_mem[u*FACTORS + k]) *
                                    longint'(item_mem[ip*FACTORS + k])));
         end
         ACT_UPDATE: begin
            bp = bias_mem[ip];
            bn = bias_mem[jn];
            x  = clip32(bp - bn);
            for (int k = 0; k < FACTORS; k++)
               x = clip32(x + rnd16(longint'(user_mem[u*FACTORS + k]) *
                      (longint'(item_mem[ip*FACTORS + k]) - longint'(item_mem[jn*FACTORS + k]))));
            // sigmoid of -x, table index clamped to the [-8, 8) span
            t = -x + (64'sd8 <<< 16);
            idx = (t < 0) ? 0 : (t >>> 12);
            if (idx > 255) idx = 255;
            tau = sigmoid_lut[idx];
            nbp = clip32(bp + rnd16(step_rate * (tau - rnd16(bias_reg * bp))));
            nbn = clip32(bn + rnd16(step_rate * (-tau - rnd16(bias_reg * bn))));
            bias_mem[ip] = int'(nbp);
            bias_mem[jn] = int'(nbn);
            for (int k = 0; k < FACTORS; k++) begin
               uk = user_mem[u*FACTORS + k];
               pk = item_mem[ip*FACTORS + k];
               nk = item_mem[jn*FACTORS + k];
               tu = rnd16(tau * uk);
               nu = clip32(uk + rnd16(step_rate * (rnd16(tau * (pk - nk)) - rnd16(factor_reg * uk))));
               np = clip32(pk + rnd16(step_rate * (tu - rnd16(factor_reg * pk))));
               nn = clip32(nk + rnd16(step_rate * (-tu - rnd16(factor_reg * nk))));
               user_mem[u*FACTORS + k]  = int'(nu);
               item_mem[ip*FACTORS + k] = int'(np);
               item_mem[jn*FACTORS + k] = int'(nn);
            end
         end
         default: ;
      endcase
      r.score = x[31:0];
      r.sat   = clip_hit;
      return r;
   endfunction

   // Send one request beat; valid stays high if the next beat follows at once
   task automatic send_beat(logic [2:0] act, int u, int ip, int jn, int fi, int signed wv);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.action         <= act;
      req_ch.user_index     <= u[9:0];
      req_ch.pos_item_index <= ip[11:0];
      req_ch.neg_item_index <= jn[11:0];
      req_ch.factor_index   <= fi[3:0];
      req_ch.write_value    <= wv;
      do @(posedge clock); while (!req_ch.ready);
      expected_scores.insert(expected_scores.size(), score_step(act, u, ip, jn, fi, wv));
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (expected_scores.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LEARN_RATE) step_rate = val;
      else if (idx == CSR_FACTOR_REG) factor_reg = val;
      else if (idx == CSR_BIAS_REG) bias_reg = val;
   endtask

   function automatic int signed small_val();
      return $signed($urandom_range(0, 262144)) - 131072;
   endfunction

   task automatic fill_user_row(int u, bit huge);
      for (int k = 0; k < FACTORS; k++)
         send_beat(ACT_WR_USER, u, 0, 0, k, huge ? 32'sh7fffffff : small_val());
   endtask

   task automatic fill_item_row(int ip, bit huge);
      for (int k = 0; k < FACTORS; k++)
         send_beat(ACT_WR_ITEM, 0, ip, 0, k, huge ? 32'sh7fffffff : small_val());
   endtask

   // Rows used by the directed part, including the corners of the index ranges
   task automatic test_table_setup();
      fill_user_row(0, 0);
      fill_user_row(NUM_USERS - 1, 0);
      fill_user_row(341, 0);
      fill_item_row(0, 0);
      fill_item_row(NUM_ITEMS - 1, 0);
      fill_item_row(2730, 0);
      fill_item_row(1365, 0);
   endtask

   task automatic test_directed();
      send_beat(ACT_PREDICT, 0, 0, 0, 0, 0);
      send_beat(ACT_WR_BIAS, 0, NUM_ITEMS - 1, 0, 0, 32'sh7fffffff);
      send_beat(ACT_WR_BIAS, 0, 0, 0, 0, 32'sh80000000);
      send_beat(ACT_PREDICT, NUM_USERS - 1, NUM_ITEMS - 1, 0, 0, 0);
      send_beat(ACT_PREDICT, 0, 0, 0, 0, 0);
      // bias difference clips at both ends
      send_beat(ACT_UPDATE, 341, NUM_ITEMS - 1, 0, 0, 0);
      send_beat(ACT_UPDATE, 341, 0, NUM_ITEMS - 1, 0, 0);
      send_beat(ACT_WR_BIAS, 0, 2730, 0, 0, 32'sh00010000);
      send_beat(ACT_UPDATE, NUM_USERS - 1, 2730, 1365, 0, 0);
      // positive and negative item the same
      send_beat(ACT_UPDATE, 0, 1365, 1365, 15, 0);
      send_beat(ACT_PREDICT, 0, 1365, 0, 0, 0);
      send_beat(ACT_SPARE_5, 5, 5, 5, 5, 32'sh12345678);
      send_beat(ACT_SPARE_6, NUM_USERS - 1, 1, 2, 3, -1);
      send_beat(ACT_SPARE_7, 0, NUM_ITEMS - 1, NUM_ITEMS - 1, 15, 32'sh80000000);
   endtask

   // Rows at full scale so the dot product clips
   task automatic test_saturation();
      fill_user_row(512, 1);
      fill_item_row(2048, 1);
      send_beat(ACT_PREDICT, 512, 2048, 0, 0, 0);
      send_beat(ACT_UPDATE, 512, 2048, 0, 0, 0);
      send_beat(ACT_UPDATE, 512, 0, 2048, 0, 0);
      send_beat(ACT_PREDICT, 512, 2048, 0, 0, 0);
      drain();
   endtask

   task automatic test_random(int beats);
      int u, ip, jn, sel;
      for (int n = 0; n < beats; n++) begin
         sel = $urandom_range(0, 99);
         u   = user_pool[$urandom_range(0, user_pool.size() - 1)];
         ip  = item_pool[$urandom_range(0, item_pool.size() - 1)];
         jn  = ($urandom_range(0, 9) == 0) ? ip
               : item_pool[$urandom_range(0, item_pool.size() - 1)];
         if (sel < 3) begin
            if ($urandom_range(0, 1)) fill_user_row($urandom_range(0, NUM_USERS - 1), 0);
            else fill_item_row($urandom_range(0, NUM_ITEMS - 1), 0);
         end else if (sel < 13) begin
            send_beat($urandom_range(0, 1) ? ACT_WR_USER : ACT_WR_ITEM,
                      $urandom_range(0, NUM_USERS - 1), $urandom_range(0, NUM_ITEMS - 1),
                      $urandom_range(0, NUM_ITEMS - 1), $urandom_range(0, 15),
                      $urandom_range(0, 7) == 0 ? $urandom() : small_val());
         end else if (sel < 22) begin
            send_beat(ACT_WR_BIAS, $urandom_range(0, NUM_USERS - 1),
                      $urandom_range(0, NUM_ITEMS - 1), $urandom_range(0, NUM_ITEMS - 1),
                      $urandom_range(0, 15),
                      $urandom_range(0, 5) == 0 ? $urandom() : small_val());
         end else if (sel < 45) begin
            send_beat(ACT_PREDICT, u, ip, $urandom_range(0, NUM_ITEMS - 1),
                      $urandom_range(0, 15), $urandom());
         end else if (sel < 96) begin
            send_beat(ACT_UPDATE, u, ip, jn, $urandom_range(0, 15), $urandom());
         end else begin
            send_beat(3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7)),
                      $urandom_range(0, NUM_USERS - 1),
                      $urandom_range(0, NUM_ITEMS - 1), $urandom_range(0, NUM_ITEMS - 1),
                      $urandom_range(0, 15), $urandom());
         end
      end
      drain();
   endtask

   task automatic test_config_sweep();
      csr_write(CSR_LEARN_RATE, 16'hffff);
      csr_write(CSR_FACTOR_REG, 16'h0000);
      csr_write(CSR_BIAS_REG, 16'hffff);
      csr_write(CSR_SPARE, 16'h1234);
      test_random(180);
      csr_write(CSR_LEARN_RATE, 16'h0000);
      csr_write(CSR_FACTOR_REG, 16'hffff);
      csr_write(CSR_BIAS_REG, 16'h0000);
      no_idle = 1'b1;
      test_random(150);
      no_idle = 1'b0;
      csr_write(CSR_LEARN_RATE, 16'($urandom_range(0, 65535)));
      csr_write(CSR_FACTOR_REG, 16'($urandom_range(0, 65535)));
      csr_write(CSR_BIAS_REG, 16'($urandom_range(0, 65535)));
      test_random(180);
   endtask

   // Result checker, sampled at the rising edge
   always @(posedge clock) begin
      score_beat_type e;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_scores.size() == 0) begin
            $error("unexpected result beat, score %0d", rsp_ch.score);
            errors++;
         end else begin
            e = expected_scores.pop_front();
            if (rsp_ch.score !== e.score) begin
               $error("score: expected %0d, got %0d", e.score, rsp_ch.score);
               errors++;
            end
            if (rsp_ch.saturated !== e.sat) begin
               $error("saturated: expected %0d, got %0d", e.sat, rsp_ch.saturated);
               errors++;
            end
         end
      end
   end

   // Result-side stalls, one draw per beat
   always @(negedge clock) begin
      if (rsp_taken) rsp_stall = no_idle ? 0 : $urandom_range(0, 8);
      if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.action         = ACT_WR_USER;
      req_ch.user_index     = '0;
      req_ch.pos_item_index = '0;
      req_ch.neg_item_index = '0;
      req_ch.factor_index   = '0;
      req_ch.write_value    = '0;
      rsp_ch.ready          = 1'b0;
      build_sigmoid();
      step_rate  = 3277;
      factor_reg = 655;
      bias_reg   = 655;
      foreach (bias_mem[i]) bias_mem[i] = 0;
      foreach (user_wr_mask[i]) user_wr_mask[i] = '0;
      foreach (item_wr_mask[i]) item_wr_mask[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_table_setup();
      test_directed();
      drain();
      test_saturation();
      test_random(200);
      test_config_sweep();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
